FILE: hw/rtl/gfr_pkg.sv
// ----------------------------------------------------------------------------
// gfr_pkg
// Shared types, constants and the CRC-8 byte update for the gamepad frame
// receiver.
// ----------------------------------------------------------------------------
package gfr_pkg;

    localparam logic [7:0] HDR_BYTE   = 8'hAA;
    localparam logic [7:0] TAIL_BYTE  = 8'hBB;
    localparam logic [7:0] CRC_POLY   = 8'h07;
    localparam logic [8:0] ALIGN_MASK = 9'h010;

    localparam int PAYLOAD_LAST = 11;

    localparam logic [3:0] POS_IDLE = 4'd0;
    localparam logic [3:0] POS_LAST = 4'd11;
    localparam logic [3:0] POS_CRC  = 4'd12;
    localparam logic [3:0] POS_TAIL = 4'd13;

    typedef logic [7:0] byte_t;
    typedef logic [3:0] pos_t;

    typedef struct packed {
        logic                            done;
        logic                            ok;
        logic [PAYLOAD_LAST:1][7:0]      payload;
    } frame_t;

    function automatic byte_t crc8_byte(input byte_t crc, input byte_t data);
        byte_t c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++)
        begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

FILE: hw/rtl/gfr_assembler.sv
// ----------------------------------------------------------------------------
// gfr_assembler
// Header hunt, payload capture, running CRC-8 and tail check for one frame.
// ----------------------------------------------------------------------------
module gfr_assembler (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           take,
    input  gfr_pkg::byte_t rx_byte,
    output gfr_pkg::frame_t frame
);
    import gfr_pkg::*;

    pos_t                        fill_reg;
    pos_t                        fill_next;
    byte_t                       crc_reg;
    byte_t                       crc_next;
    logic                        crc_match_reg;
    logic                        crc_match_next;
    logic [PAYLOAD_LAST:1][7:0]  payload_reg;

    always_comb
    begin
        fill_next      = fill_reg;
        crc_next       = crc_reg;
        crc_match_next = crc_match_reg;
        if (take)
        begin
            case (fill_reg)
                POS_IDLE:
                begin
                    if (rx_byte == HDR_BYTE)
                    begin
                        fill_next = fill_reg + 4'd1;
                        crc_next  = '0;
                    end
                end
                POS_CRC:
                begin
                    crc_match_next = (crc_reg == rx_byte);
                    fill_next      = POS_TAIL;
                end
                POS_TAIL:
                begin
                    fill_next = POS_IDLE;
                end
                default:
                begin
                    crc_next  = crc8_byte(crc_reg, rx_byte);
                    fill_next = fill_reg + 4'd1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= POS_IDLE;
            crc_reg       <= '0;
            crc_match_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            crc_reg       <= crc_next;
            crc_match_reg <= crc_match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 1; i <= PAYLOAD_LAST; i++)
        begin
            if (take && fill_reg == 4'(i))
                payload_reg[i] <= rx_byte;
        end
    end

    assign frame.done    = take && (fill_reg == POS_TAIL);
    assign frame.ok      = crc_match_reg && (rx_byte == TAIL_BYTE);
    assign frame.payload = payload_reg;

endmodule

FILE: hw/rtl/gamepad_frame_receiver_crc8_top.sv
// ----------------------------------------------------------------------------
// gamepad_frame_receiver_crc8_top
// Takes one received byte per cycle while the input is not stalled: a
// running CRC-8 is folded in as each payload byte arrives, and a frame is
// 14 bytes long. The result of a frame is registered and shows on the output
// in the cycle after its closing byte is taken. The input stalls only while a
// result waits in the output register and the output is stalled. The stick,
// press and keypad values are held registers that change only on a good frame.
// ----------------------------------------------------------------------------
module gamepad_frame_receiver_crc8_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  gfr_pkg::byte_t      rx_byte,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                frame_ok,
    output logic signed [15:0]  left_x,
    output logic signed [15:0]  left_y,
    output logic signed [15:0]  right_x,
    output logic signed [15:0]  right_y,
    output logic                stick_press_left,
    output logic                stick_press_right,
    output logic [8:0]          keypad_state,
    output logic [8:0]          release_events,
    output logic [8:0]          published_events
);
    import gfr_pkg::*;

    frame_t       frame;
    logic         take;
    logic         good;
    logic [8:0]   keys_now;
    logic [8:0]   release_next;

    logic         align_reg;
    logic         out_valid_reg;
    logic         out_valid_next;
    logic         frame_ok_reg;
    logic [15:0]  left_x_reg;
    logic [15:0]  left_y_reg;
    logic [15:0]  right_x_reg;
    logic [15:0]  right_y_reg;
    logic [1:0]   presses_reg;
    logic [8:0]   keypad_reg;
    logic [8:0]   release_reg;
    logic [8:0]   published_reg;

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg && out_stall;
    assign take      = in_valid && !in_stall;

    gfr_assembler u_assembler (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .rx_byte (rx_byte),
        .frame   (frame)
    );

    assign good         = frame.done && frame.ok;
    assign keys_now     = {frame.payload[10][0], frame.payload[11]};
    assign release_next = good ? (keypad_reg & ~keys_now) : '0;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (!out_stall)
            out_valid_next = 1'b0;
        if (frame.done)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            align_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            left_x_reg    <= '0;
            left_y_reg    <= '0;
            right_x_reg   <= '0;
            right_y_reg   <= '0;
            presses_reg   <= '0;
            keypad_reg    <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                align_reg <= cfg_data;
            out_valid_reg <= out_valid_next;
            if (good)
            begin
                left_x_reg  <= {frame.payload[1], frame.payload[2]};
                left_y_reg  <= {frame.payload[3], frame.payload[4]};
                right_x_reg <= {frame.payload[5], frame.payload[6]};
                right_y_reg <= {frame.payload[7], frame.payload[8]};
                presses_reg <= frame.payload[9][1:0];
                keypad_reg  <= keys_now;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame.done)
        begin
            frame_ok_reg  <= frame.ok;
            release_reg   <= release_next;
            published_reg <= align_reg ? (release_next & ALIGN_MASK) : release_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign frame_ok          = frame_ok_reg;
    assign left_x            = left_x_reg;
    assign left_y            = left_y_reg;
    assign right_x           = right_x_reg;
    assign right_y           = right_y_reg;
    assign stick_press_left  = presses_reg[0];
    assign stick_press_right = presses_reg[1];
    assign keypad_state      = keypad_reg;
    assign release_events    = release_reg;
    assign published_events  = published_reg;

    a_release_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && release_events != '0 |-> frame_ok)
        else $error("release events on a bad frame");

    a_published_subset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (published_events & ~release_events) == '0)
        else $error("published event without release");

    a_bad_frame_keeps_keys: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !frame_ok |-> $stable(keypad_state))
        else $error("keypad changed on a bad frame");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(left_x) && $stable(release_events))
        else $error("result changed while stalled");

endmodule
